FILE: rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared constants and types for the reply frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int         RFC_MAX_FRAME_BYTES = 256;
    localparam logic [7:0] RFC_DEFAULT_HEADER  = 8'h77;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_CHECKSUM = 2'd1,
        VERDICT_HEADER   = 2'd2,
        VERDICT_LENGTH   = 2'd3
    } t_verdict;

    typedef struct packed {
        logic       valid;
        logic [7:0] body_byte;
        logic [7:0] body_index;
        logic       frame_end;
        t_verdict   verdict;
    } t_result;

endpackage

FILE: rtl/rfc_if.sv
// ----------------------------------------------------------------------------
// rfc_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface rfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic [7:0] body_index;
    logic       frame_end;
    logic [1:0] verdict;

    modport source (output valid, output body_byte, output body_index,
                    output frame_end, output verdict, input ready);
    modport sink   (input valid, input body_byte, input body_index,
                    input frame_end, input verdict, output ready);
endinterface

FILE: rtl/rfc_frame_core.sv
// ----------------------------------------------------------------------------
// rfc_frame_core
// Frame state per byte request: position, count, running sum, header match,
// and the result that the accepted byte gives.
// ----------------------------------------------------------------------------
module rfc_frame_core #(
    parameter int MAX_FRAME_BYTES = rfc_pkg::RFC_MAX_FRAME_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_expected_header,
    output rfc_pkg::t_result    o_result
);
    import rfc_pkg::*;

    localparam logic [8:0] LAST_POS = 9'(MAX_FRAME_BYTES);

    logic [7:0] r_position, n_position;
    logic [7:0] r_length,   n_length;
    logic [7:0] r_sum,      n_sum;
    logic       r_header_ok, n_header_ok;

    logic [7:0] length_now;
    logic [7:0] pos_minus_one;
    logic       last;
    t_verdict   verdict;

    always_comb begin
        length_now    = (r_position == 8'd1) ? i_rx_byte : r_length;
        pos_minus_one = r_position - 8'd1;
        last          = (pos_minus_one >= length_now) ||
                        (({1'b0, r_position} + 9'd1) >= LAST_POS);

        if (r_sum != i_rx_byte) begin
            verdict = VERDICT_CHECKSUM;
        end else if (!r_header_ok) begin
            verdict = VERDICT_HEADER;
        end else if (pos_minus_one != length_now) begin
            verdict = VERDICT_LENGTH;
        end else begin
            verdict = VERDICT_OK;
        end

        n_position  = r_position;
        n_length    = r_length;
        n_sum       = r_sum;
        n_header_ok = r_header_ok;
        o_result    = '0;

        if (r_position == 8'd0) begin
            n_header_ok = (i_rx_byte == i_expected_header);
            n_sum       = i_rx_byte;
            n_position  = 8'd1;
        end else if (!last) begin
            n_length   = length_now;
            n_sum      = r_sum + i_rx_byte;
            n_position = r_position + 8'd1;
            if (r_position != 8'd1) begin
                o_result.valid      = 1'b1;
                o_result.body_byte  = i_rx_byte;
                o_result.body_index = r_position - 8'd2;
            end
        end else begin
            o_result.valid     = 1'b1;
            o_result.frame_end = 1'b1;
            o_result.verdict   = verdict;
            n_position  = 8'd0;
            n_length    = 8'd0;
            n_sum       = 8'd0;
            n_header_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= 8'd0;
            r_length    <= 8'd0;
            r_sum       <= 8'd0;
            r_header_ok <= 1'b0;
        end else if (i_accept) begin
            r_position  <= n_position;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_header_ok <= n_header_ok;
        end
    end

endmodule

FILE: rtl/reply_frame_checker.sv
// ----------------------------------------------------------------------------
// reply_frame_checker
// Checks reply frames (header, count, body, additive checksum) byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per request. o_res carries one result
//   per body byte (status and data, with its index in the body) and one
//   verdict result on the last byte of each frame (frame_end high).
//   Header and count bytes give no result unless the frame ends on the count.
//   i_cfg_wr_en / i_cfg_wr_data set the expected header byte.
// Output: a result appears on o_res in the cycle after its byte is taken.
// Throughput: one byte per cycle unless o_res stalls; state update and result
//   logic sit between the frame state regs and the single output register.
// Reset: the expected header returns to 0x77, the frame state clears and
//   the output register empties.
// Stall: while a result waits on o_res with ready low, i_rx.ready is low
//   and the result is held; when it is taken a new byte can enter in the
//   same cycle.
// ----------------------------------------------------------------------------
module reply_frame_checker #(
    parameter int MAX_FRAME_BYTES = rfc_pkg::RFC_MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    rfc_rx_if.sink      i_rx,
    rfc_res_if.source   o_res
);
    import rfc_pkg::*;

    logic [7:0] r_expected_header;
    logic       accept;
    t_result    result;
    logic       r_out_valid;
    logic [7:0] r_body_byte;
    logic [7:0] r_body_index;
    logic       r_frame_end;
    t_verdict   r_verdict;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_header <= RFC_DEFAULT_HEADER;
        end else if (i_cfg_wr_en) begin
            r_expected_header <= i_cfg_wr_data;
        end
    end

    rfc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx.rx_byte),
        .i_expected_header (r_expected_header),
        .o_result          (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_out_valid <= accept && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && result.valid) begin
            r_body_byte  <= result.body_byte;
            r_body_index <= result.body_index;
            r_frame_end  <= result.frame_end;
            r_verdict    <= result.verdict;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.body_byte  = r_body_byte;
    assign o_res.body_index = r_body_index;
    assign o_res.frame_end  = r_frame_end;
    assign o_res.verdict    = r_verdict;

endmodule

FILE: rtl/rfc_checker.sv
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the reply frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module rfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_body_byte,
    input logic [7:0] i_body_index,
    input logic       i_frame_end,
    input logic [1:0] i_verdict
);
    import rfc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_body_byte) &&
        $stable(i_body_index) && $stable(i_frame_end) && $stable(i_verdict))
        else $error("stalled result changed");

    a_stall_blocks_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_rx_ready)
        else $error("byte request taken while result stalled");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_frame_end |-> i_body_byte == 8'd0 && i_body_index == 8'd0)
        else $error("verdict result carries body fields");

    a_body_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_frame_end |-> i_verdict == VERDICT_OK)
        else $error("body result carries a verdict");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind reply_frame_checker rfc_checker u_rfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rx_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_body_byte  (o_res.body_byte),
    .i_body_index (o_res.body_index),
    .i_frame_end  (o_res.frame_end),
    .i_verdict    (o_res.verdict)
);

FILE: tb/rfc_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_frame_monitor
// Watches the byte and result channels of the reply frame checker, tracks
// the frame state of every accepted byte, and compares each accepted result
// in order with the body or verdict result that byte should have caused.
// ----------------------------------------------------------------------------
module rfc_frame_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    rfc_rx_if          i_rx,
    rfc_res_if         i_res,
    output int         o_fail_count,
    output int         o_pending,
    output logic [7:0] o_frame_pos
);
    import rfc_pkg::*;

    logic [7:0] header_reg;
    logic [7:0] frame_pos;
    logic [7:0] count_byte;
    logic [7:0] frame_sum;
    logic       header_match;
    t_result    results_due[$];
    t_result    got;
    t_result    want;

    assign o_frame_pos = frame_pos;

    task automatic report_mismatch(input string what);
        string got_s;
        string want_s;
        got_s  = $sformatf("byte %02h idx %0d end %0b verdict %0d",
                           got.body_byte, got.body_index, got.frame_end, got.verdict);
        want_s = $sformatf("byte %02h idx %0d end %0b verdict %0d",
                           want.body_byte, want.body_index, want.frame_end, want.verdict);
        $display("%0t mismatch, %s: got %s, want %s", $time, what, got_s, want_s);
        o_fail_count++;
    endtask

    task automatic clear_frame();
        frame_pos    = 8'd0;
        count_byte   = 8'd0;
        frame_sum    = 8'd0;
        header_match = 1'b0;
    endtask

    task automatic track_frame_byte(input logic [7:0] b);
        t_result r;
        int      p;
        logic    closes;
        r       = '0;
        r.valid = 1'b1;
        p       = frame_pos;
        if (p == 0) begin
            header_match = (b == header_reg);
            frame_sum    = b;
            frame_pos    = 8'd1;
        end else begin
            if (p == 1) begin
                count_byte = b;
            end
            closes = ((p - 1) >= int'(count_byte)) || ((p + 1) >= RFC_MAX_FRAME_BYTES);
            if (!closes) begin
                frame_sum = frame_sum + b;
                frame_pos = 8'(p + 1);
                if (p != 1) begin
                    r.body_byte  = b;
                    r.body_index = 8'(p - 2);
                    results_due.push_back(r);
                end
            end else begin
                r.frame_end = 1'b1;
                if (frame_sum != b) begin
                    r.verdict = VERDICT_CHECKSUM;
                end else if (!header_match) begin
                    r.verdict = VERDICT_HEADER;
                end else if ((p - 1) != int'(count_byte)) begin
                    r.verdict = VERDICT_LENGTH;
                end else begin
                    r.verdict = VERDICT_OK;
                end
                results_due.push_back(r);
                clear_frame();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            header_reg   = RFC_DEFAULT_HEADER;
            o_fail_count = 0;
            clear_frame();
            results_due.delete();
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                track_frame_byte(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                got            = '0;
                got.valid      = 1'b1;
                got.body_byte  = i_res.body_byte;
                got.body_index = i_res.body_index;
                got.frame_end  = i_res.frame_end;
                got.verdict    = t_verdict'(i_res.verdict);
                if (results_due.size() == 0) begin
                    want = '0;
                    report_mismatch("result with nothing due");
                end else begin
                    want = results_due.pop_front();
                    if (got.body_byte !== want.body_byte || got.body_index !== want.body_index ||
                        got.frame_end !== want.frame_end || got.verdict !== want.verdict) begin
                        report_mismatch("wrong field");
                    end
                end
            end
            if (i_cfg_wr_en) begin
                header_reg = i_cfg_wr_data;
            end
        end
        o_pending = results_due.size();
    end

endmodule

FILE: tb/reply_frame_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_frame_checker_test
// Drives reply frames into the checker: a short directed set, then random
// phases of good, corrupted and junk frames under several expected headers,
// with bursts of idling on both channels. The monitor checks every result.
// ----------------------------------------------------------------------------
module reply_frame_checker_test;
    import rfc_pkg::*;

    localparam int ITEMS       = 1900;
    localparam int STEADY_FROM = 1650;
    localparam int STALL_LIMIT = 1000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    int         fail_count;
    int         pending;
    logic [7:0] frame_pos;
    int         bytes_sent;
    int         idle_level;
    bit         steady;
    int         stall_left;
    int         quiet_cycles;
    logic [7:0] header_now;

    rfc_rx_if  rx_if ();
    rfc_res_if res_if ();

    reply_frame_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_if),
        .o_res         (res_if)
    );

    rfc_frame_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_if),
        .i_res         (res_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_frame_pos   (frame_pos)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit idle_hit();
        if (steady || idle_level == 0) begin
            return 1'b0;
        end
        return $urandom_range(0, (idle_level == 1) ? 11 : 3) == 0;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 12);
        end else if (r < 98) begin
            return $urandom_range(13, 60);
        end else if (r < 99) begin
            return $urandom_range(200, 254);
        end
        return 255;
    endfunction

    // hold the result channel in random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_hit()) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("reply_frame_checker regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_hit()) begin
            gap = $urandom_range(1, 3);
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
        if (bytes_sent >= STEADY_FROM) begin
            steady = 1'b1;
        end
    endtask

    task automatic send_frame(input logic [7:0] hdr, input int cnt, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         n_body;
        n_body = (cnt == 255) ? 253 : cnt - 1;
        send_byte(hdr);
        sum = hdr;
        send_byte(8'(cnt));
        if (cnt == 0) begin
            return;
        end
        sum = sum + 8'(cnt);
        for (int i = 0; i < n_body; i++) begin
            b   = pick_byte();
            sum = sum + b;
            send_byte(b);
        end
        send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    // drop the request line and let the block drain before a header change
    task automatic set_header(input logic [7:0] h);
        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= h;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
        header_now = h;
    endtask

    initial begin
        int         phase;
        int         n_frames;
        int         kind;
        logic [7:0] h;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 8'h00;
        i_rst_n       = 1'b0;
        header_now    = RFC_DEFAULT_HEADER;
        idle_level    = 0;
        steady        = 1'b0;
        bytes_sent    = 0;
        stall_left    = 0;
        quiet_cycles  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_frame(RFC_DEFAULT_HEADER, 1, 1'b0);
        send_frame(RFC_DEFAULT_HEADER, 0, 1'b0);
        send_frame(8'h5a, 2, 1'b0);
        send_byte(RFC_DEFAULT_HEADER);
        send_byte(8'd3);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(RFC_DEFAULT_HEADER + 8'd3 + 8'hff);
        set_header(8'h00);
        send_frame(8'h00, 0, 1'b0);
        set_header(8'hff);
        send_frame(8'hff, 1, 1'b0);
        send_frame(8'h00, 2, 1'b1);

        phase = 0;
        while (bytes_sent < ITEMS) begin
            case (phase)
                0: h = RFC_DEFAULT_HEADER;
                1: h = 8'h00;
                2: h = 8'hff;
                default: h = 8'($urandom);
            endcase
            set_header(h);
            idle_level = $urandom_range(0, 2);
            n_frames   = $urandom_range(15, 40);
            for (int f = 0; f < n_frames && bytes_sent < ITEMS; f++) begin
                kind = $urandom_range(0, 99);
                if (phase == 1 && f < 2) begin
                    send_frame(header_now, 255 - f, 1'b0);
                end else if (kind < 65) begin
                    send_frame(header_now, pick_count(), 1'b0);
                end else if (kind < 77) begin
                    send_frame(header_now, pick_count(), 1'b1);
                end else if (kind < 89) begin
                    send_frame(header_now ^ 8'($urandom_range(1, 255)), pick_count(),
                               $urandom_range(0, 1));
                end else if (kind < 97) begin
                    send_frame(8'($urandom), pick_count(), $urandom_range(0, 1));
                end else begin
                    // junk bytes, then advance until the frame closes
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
                    while (frame_pos != 0) send_byte(8'($urandom));
                end
            end
            phase++;
        end

        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("reply_frame_checker regression: pass");
        end else begin
            $display("reply_frame_checker regression: fail");
        end
        $finish;
    end

endmodule

FILE: reply_frame_checker.f
rtl/rfc_pkg.sv
rtl/rfc_if.sv
rtl/rfc_frame_core.sv
rtl/reply_frame_checker.sv
rtl/rfc_checker.sv
tb/rfc_frame_monitor.sv
tb/reply_frame_checker_test.sv
